// ===== design/pidaw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidaw_pkg
// shared types, constants and saturation helpers of the pid controller
// ----------------------------------------------------------------------------
package pidaw_pkg;

   localparam int DataW = 32;
   localparam int ProdW = 64;
   localparam int QShift = 16;
   localparam logic signed [DataW-1:0] S32Max = 32'sh7FFF_FFFF;
   localparam logic signed [DataW-1:0] S32Min = 32'sh8000_0000;

   // register map
   localparam logic [3:0] RegKp = 4'd0;
   localparam logic [3:0] RegKi = 4'd1;
   localparam logic [3:0] RegKd = 4'd2;
   localparam logic [3:0] RegKf = 4'd3;
   localparam logic [3:0] RegILim = 4'd4;
   localparam logic [3:0] RegOutMin = 4'd5;
   localparam logic [3:0] RegOutMax = 4'd6;
   localparam logic [3:0] RegRamp = 4'd7;

   typedef enum logic [4:0] {
      ST_IDLE, ST_ERR, ST_F, ST_P, ST_DM, ST_DMUL, ST_DDIV, ST_DFIN,
      ST_IMUL, ST_IDIV, ST_IFIN, ST_TMUL, ST_TDIG, ST_SUM, ST_BDIV, ST_BWAIT,
      ST_UPD
   } state_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // saturate a 66-bit signed value to 32 bits
   function automatic logic signed [DataW-1:0] sat66(input logic signed [65:0] v);
      logic signed [DataW-1:0] r;
      if (v > 66'sh0_0000_0000_7FFF_FFFF) r = S32Max;
      else if (v < -66'sh0_0000_0000_8000_0000) r = S32Min;
      else r = v[DataW-1:0];
      return r;
   endfunction

   // signed value from a magnitude and a sign, saturated to 32 bits
   function automatic logic signed [DataW-1:0] sat_mag(input logic neg,
                                                       input logic [ProdW-1:0] q);
      logic signed [DataW-1:0] r;
      if (!neg) r = (q > 64'h7FFF_FFFF) ? S32Max : q[DataW-1:0];
      else r = (q > 64'h8000_0000) ? S32Min : (~q[DataW-1:0] + 32'd1);
      return r;
   endfunction

   // q16.16 product scaled back, truncating toward zero
   function automatic logic signed [DataW-1:0] qscale(input logic signed [ProdW-1:0] p);
      logic signed [ProdW:0] t;
      t = {p[ProdW-1], p} + (p[ProdW-1] ? 65'sd65535 : 65'sd0);
      t = t >>> QShift;
      return sat66({t[ProdW], t});
   endfunction

   function automatic logic signed [33:0] clamp34(input logic signed [33:0] v,
                                                  input logic signed [33:0] lo,
                                                  input logic signed [33:0] hi);
      logic signed [33:0] r;
      if (v < lo) r = lo;
      else if (v > hi) r = hi;
      else r = v;
      return r;
   endfunction

endpackage

// ===== design/pidaw_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidaw_mul
// shared signed 32x32 multiplier with registered product
// ----------------------------------------------------------------------------
module pidaw_mul (
   input  logic                                    clock,
   input  logic signed [pidaw_pkg::DataW-1:0]      op_a,
   input  logic signed [pidaw_pkg::DataW-1:0]      op_b,
   output logic signed [pidaw_pkg::ProdW-1:0]      prod
);
   import pidaw_pkg::*;

   logic signed [ProdW-1:0] prod_ff;
   logic signed [ProdW-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== design/pidaw_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidaw_div
// restoring unsigned divider, 64-bit dividend by 32-bit divisor, one bit a cycle
// ----------------------------------------------------------------------------
module pidaw_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pidaw_pkg::div_ctrl_type              ctrl,
   input  logic [pidaw_pkg::ProdW-1:0]          dividend,
   input  logic [pidaw_pkg::DataW-1:0]          divisor,
   output pidaw_pkg::div_stat_type              stat,
   output logic [pidaw_pkg::ProdW-1:0]          quotient
);
   import pidaw_pkg::*;

   logic [DataW-1:0] rem_ff, rem_in;
   logic [ProdW-1:0] quo_ff, quo_in;
   logic [DataW-1:0] dvs_ff, dvs_in;
   logic [6:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DataW:0]   trial;

   assign trial = {rem_ff, quo_ff[ProdW-1]};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = 7'(ProdW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DataW'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[ProdW-2:0], 1'b1};
         end else begin
            rem_in = trial[DataW-1:0];
            quo_in = {quo_ff[ProdW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

// ===== design/pid_controller_with_antiwindup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_with_antiwindup
// q16.16 pid controller with feedforward, integral anti-windup, ramp and output limits
// ----------------------------------------------------------------------------
// channel  dir  beat contents
// req      in   tdata: measured[31:0], target[63:32]; tuser: restart
// rsp      out  tdata: drive[31:0]
// csr      in   write enable, register index, 32-bit data
//
// when the i limit and ki are both nonzero, a beat also waits on the 64-step divider
// that computes the error-sum bound
// the two tick-scale divisions run as three 16-bit digits each through the shared
// multiplier with a reciprocal of the tick divisor
// req_tready is high only while the sequencer is idle, which it enters as it registers the result
// a finished drive waits in the output register; the next req beat is taken meanwhile
// synchronous active-high reset sets the first-tick flag and clears history and configuration registers
// ----------------------------------------------------------------------------
module pid_controller_with_antiwindup #(
   parameter int TICK_DIVISOR = 60
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // measured[31:0], target[63:32]
   input  logic        req_tuser,   // restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // drive[31:0]
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import pidaw_pkg::*;

   // tick-scale division: drop the q16.16 scale, then divide by the tick divisor
   // digit by digit; a partial remainder is 10 bits of remainder and a 16-bit digit
   localparam int RecipShift = 26 + $clog2(TICK_DIVISOR);
   localparam logic [ProdW-1:0] RecipWide =
      ((64'd1 << RecipShift) + 64'(TICK_DIVISOR) - 64'd1) / 64'(TICK_DIVISOR);
   localparam logic signed [DataW-1:0] RecipMul = DataW'(RecipWide);
   localparam logic [31:0] TickDivW = 32'(TICK_DIVISOR);

   // configuration
   logic signed [DataW-1:0] kp_ff, ki_ff, kd_ff, kf_ff, omin_ff, omax_ff;
   logic [30:0]             ilim_ff, ramp_ff;

   // controller history
   logic signed [DataW-1:0] esum_ff, esum_in;
   logic signed [DataW-1:0] pmeas_ff, pmeas_in;
   logic signed [DataW-1:0] pdrv_ff, pdrv_in;
   logic                    first_ff, first_in;

   // per-beat work registers
   state_type               state_ff, state_in;
   logic signed [DataW-1:0] meas_ff, meas_in, tgt_ff, tgt_in;
   logic signed [DataW-1:0] err_ff, err_in, f_ff, f_in, p_ff, p_in;
   logic signed [DataW-1:0] dm_ff, dm_in, d_ff, d_in, i_ff, i_in;
   logic signed [DataW-1:0] drv_ff, drv_in, b_ff, b_in;
   logic                    neg_ff, neg_in;
   logic                    ovld_ff, ovld_in;
   logic [DataW-1:0]        odata_ff, odata_in;

   // tick-scale division digits
   logic [47:0]             tnum_ff, tnum_in, tquo_ff, tquo_in;
   logic [9:0]              trem_ff, trem_in;
   logic [1:0]              tcnt_ff, tcnt_in;
   logic                    tsel_ff, tsel_in;   // set while the i term is divided
   logic [25:0]             tcur, tback;
   logic [15:0]             tdig;

   // shared units
   logic signed [DataW-1:0] mul_a, mul_b;
   logic signed [ProdW-1:0] prod;
   logic [ProdW-1:0]        prod_mag;
   div_ctrl_type            div_ctrl;
   div_stat_type            div_stat;
   logic [ProdW-1:0]        div_dvd, quo;
   logic [DataW-1:0]        div_dvs;

   logic                    lim_on;
   logic signed [33:0]      rlo, rhi, dv;
   logic signed [DataW-1:0] sum_sat;
   logic [DataW-1:0]        ki_mag;

   pidaw_mul u_mul (.clock(clock), .op_a(mul_a), .op_b(mul_b), .prod(prod));

   pidaw_div u_div (
      .clock(clock), .reset(reset), .ctrl(div_ctrl), .dividend(div_dvd),
      .divisor(div_dvs), .stat(div_stat), .quotient(quo)
   );

   assign lim_on = (omin_ff != omax_ff);
   assign rlo    = 34'(pdrv_ff) - 34'(signed'({1'b0, ramp_ff}));
   assign rhi    = 34'(pdrv_ff) + 34'(signed'({1'b0, ramp_ff}));
   assign ki_mag = ki_ff[DataW-1] ? (~ki_ff + 32'd1) : ki_ff;
   assign sum_sat = sat66(66'(esum_ff) + 66'(err_ff));
   assign req_tready = (state_ff == ST_IDLE);

   assign prod_mag = prod[ProdW-1] ? (~prod + 64'd1) : prod;
   // partial remainder, its quotient digit by reciprocal and the digit times divisor
   assign tcur  = {trem_ff, tnum_ff[47:32]};
   assign tdig  = 16'(prod >>> RecipShift);
   assign tback = 26'(32'(tdig) * TickDivW);

   // config write port, index beyond the map is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= '0; ki_ff <= '0; kd_ff <= '0; kf_ff <= '0;
         ilim_ff <= '0; omin_ff <= '0; omax_ff <= '0; ramp_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            RegKp:     kp_ff <= csr_wdata;
            RegKi:     ki_ff <= csr_wdata;
            RegKd:     kd_ff <= csr_wdata;
            RegKf:     kf_ff <= csr_wdata;
            RegILim:   ilim_ff <= csr_wdata[30:0];
            RegOutMin: omin_ff <= csr_wdata;
            RegOutMax: omax_ff <= csr_wdata;
            RegRamp:   ramp_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         esum_ff  <= '0;
         pmeas_ff <= '0;
         pdrv_ff  <= '0;
         first_ff <= 1'b1;
         ovld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         esum_ff  <= esum_in;
         pmeas_ff <= pmeas_in;
         pdrv_ff  <= pdrv_in;
         first_ff <= first_in;
         ovld_ff  <= ovld_in;
      end
      meas_ff <= meas_in; tgt_ff <= tgt_in; err_ff <= err_in;
      f_ff <= f_in; p_ff <= p_in; dm_ff <= dm_in; d_ff <= d_in;
      i_ff <= i_in; drv_ff <= drv_in; b_ff <= b_in; neg_ff <= neg_in;
      odata_ff <= odata_in;
      tnum_ff <= tnum_in; tquo_ff <= tquo_in; trem_ff <= trem_in;
      tcnt_ff <= tcnt_in; tsel_ff <= tsel_in;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      esum_in = esum_ff; pmeas_in = pmeas_ff; pdrv_in = pdrv_ff; first_in = first_ff;
      meas_in = meas_ff; tgt_in = tgt_ff; err_in = err_ff; f_in = f_ff; p_in = p_ff;
      dm_in = dm_ff; d_in = d_ff; i_in = i_ff; drv_in = drv_ff; b_in = b_ff;
      neg_in = neg_ff; odata_in = odata_ff;
      tnum_in = tnum_ff; tquo_in = tquo_ff; trem_in = trem_ff;
      tcnt_in = tcnt_ff; tsel_in = tsel_ff;
      ovld_in = ovld_ff && !rsp_tready;
      mul_a = kf_ff; mul_b = tgt_ff;
      div_ctrl.start = 1'b0;
      // the divider only serves the error-sum bound: i limit over |ki|
      div_dvd = {17'd0, ilim_ff, 16'd0};
      div_dvs = ki_mag;
      dv = 34'(drv_ff);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               meas_in = req_tdata[31:0];
               tgt_in  = req_tdata[63:32];
               if (req_tuser) begin
                  esum_in  = '0;
                  first_in = 1'b1;
               end
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            // kf*target goes into the multiplier
            err_in   = sat66(66'(tgt_ff) - 66'(meas_ff));
            state_in = ST_F;
         end
         ST_F: begin
            f_in  = qscale(prod);
            mul_a = kp_ff; mul_b = err_ff;
            state_in = ST_P;
         end
         ST_P: begin
            p_in = qscale(prod);
            // first tick seeds the history
            if (first_ff) begin
               pmeas_in = meas_ff;
               pdrv_in  = sat66(66'(qscale(prod)) + 66'(f_ff));
               first_in = 1'b0;
            end
            state_in = ST_DM;
         end
         ST_DM: begin
            dm_in    = sat66(66'(meas_ff) - 66'(pmeas_ff));
            state_in = ST_DMUL;
         end
         ST_DMUL: begin
            mul_a = kd_ff; mul_b = dm_ff;
            pmeas_in = meas_ff;
            state_in = ST_DDIV;
         end
         ST_DDIV: begin
            // magnitude over 65536 goes to the digit loop
            neg_in   = prod[ProdW-1];
            tnum_in  = prod_mag[ProdW-1:16];
            trem_in  = '0;
            tcnt_in  = 2'd2;
            tsel_in  = 1'b0;
            state_in = ST_TMUL;
         end
         ST_DFIN: begin
            // d term carries the opposite sign of kd*delta
            d_in     = sat_mag(!neg_ff, {16'd0, tquo_ff});
            state_in = ST_IMUL;
         end
         ST_IMUL: begin
            mul_a = ki_ff; mul_b = esum_ff;
            state_in = ST_IDIV;
         end
         ST_IDIV: begin
            neg_in   = prod[ProdW-1];
            tnum_in  = prod_mag[ProdW-1:16];
            trem_in  = '0;
            tcnt_in  = 2'd2;
            tsel_in  = 1'b1;
            state_in = ST_TMUL;
         end
         ST_IFIN: begin
            i_in = sat_mag(neg_ff, {16'd0, tquo_ff});
            if (ilim_ff != '0)
               i_in = DataW'(clamp34(34'(sat_mag(neg_ff, {16'd0, tquo_ff})),
                                     -34'(signed'({1'b0, ilim_ff})),
                                     34'(signed'({1'b0, ilim_ff}))));
            state_in = ST_SUM;
         end
         ST_TMUL: begin
            // partial remainder times the reciprocal of the tick divisor
            mul_a = {6'd0, tcur};
            mul_b = RecipMul;
            state_in = ST_TDIG;
         end
         ST_TDIG: begin
            trem_in = 10'(tcur - tback);
            tquo_in = {tquo_ff[31:0], tdig};
            tnum_in = {tnum_ff[31:0], 16'd0};
            if (tcnt_ff != 2'd0) begin
               tcnt_in  = tcnt_ff - 2'd1;
               state_in = ST_TMUL;
            end else if (tsel_ff) begin
               state_in = ST_IFIN;
            end else begin
               state_in = ST_DFIN;
            end
         end
         ST_SUM: begin
            drv_in   = sat66(66'(f_ff) + 66'(p_ff) + 66'(i_ff) + 66'(d_ff));
            state_in = ST_BDIV;
         end
         ST_BDIV: begin
            // bound on the error sum: i limit over |ki|
            b_in = S32Max;
            if (ilim_ff != '0 && ki_ff != '0) begin
               div_ctrl.start = 1'b1;
               state_in = ST_BWAIT;
            end else begin
               state_in = ST_UPD;
            end
         end
         ST_BWAIT: begin
            if (div_stat.done) begin
               b_in     = sat_mag(1'b0, quo);
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            // anti-windup, then ramp and output clamps; wait for a free output
            if (!ovld_ff || rsp_tready) begin
               if (lim_on && !(omin_ff < drv_ff && drv_ff < omax_ff))
                  esum_in = err_ff;
               else if (ramp_ff != '0 && !(rlo < 34'(drv_ff) && 34'(drv_ff) < rhi))
                  esum_in = err_ff;
               else if (ilim_ff != '0)
                  esum_in = DataW'(clamp34(34'(sum_sat), -34'(b_ff), 34'(b_ff)));
               else
                  esum_in = sum_sat;
               if (ramp_ff != '0) dv = clamp34(dv, rlo, rhi);
               if (lim_on) dv = clamp34(dv, 34'(omin_ff), 34'(omax_ff));
               pdrv_in  = sat66(66'(dv));
               odata_in = sat66(66'(dv));
               ovld_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = odata_ff;

   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_stat.busy) else $error("divider busy while idle");
   a_out_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && omin_ff < omax_ff)
      |-> (signed'(rsp_tdata) >= omin_ff && signed'(rsp_tdata) <= omax_ff))
      else $error("drive outside output limits");
   a_reset: assert property (@(posedge clock)
      reset |=> (state_ff == ST_IDLE && first_ff && !rsp_tvalid))
      else $error("reset state wrong");

endmodule
